// File: rtl/core/overwriting_byte_ring_buffer_defines.svh
// assertion macros for the overwriting byte ring buffer checker
`ifndef OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH
`define OVERWRITING_BYTE_RING_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define OBRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obrb check failed");

// next-cycle implication, sampled on clk, off during reset
`define OBRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obrb check failed");

`endif

// File: rtl/core/obrb_pkg.sv
// shared types and constants of the overwriting byte ring buffer
`default_nettype none
package obrb_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int MAX_READ_DEF = 32;

  // width of the saturated read length and of the remaining-byte counter
  localparam int RLW = 7;

  typedef struct packed {
    logic       req_type;
    logic [7:0] write_byte;
    logic [5:0] read_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       last;
    logic       no_data;
    logic [8:0] fill_level;
  } out_item_t;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic wr;        // store a byte
    logic rd_start;  // first byte of a read, load the counter
    logic rd_next;   // following byte of a read
    logic capture;   // load the output register from ram data
    logic empty;     // load the output register with a no-data result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic n_zero;    // the request at the input would return nothing
    logic out_last;  // the held result closes its read
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/obrb_ram.sv
// generic single-port-write, registered-read ram
`default_nettype none
module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/obrb_ctrl.sv
// controller state machine of the overwriting byte ring buffer
`default_nettype none
module obrb_ctrl import obrb_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    req_type,
  output      logic    in_ready,
  output      logic    out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output      cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_OUT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   in_acc, out_acc, is_read;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;
  assign is_read   = (req_type == REQ_READ);

  always_comb begin
    cmd.wr       = in_acc & ~is_read;
    cmd.rd_start = in_acc & is_read & ~status.n_zero;
    cmd.empty    = in_acc & is_read & status.n_zero;
    cmd.capture  = (state_r == S_FETCH);
    cmd.rd_next  = out_acc & ~status.out_last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && is_read) begin
          state_nxt = status.n_zero ? S_OUT : S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_nxt = status.out_last ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/obrb_dp.sv
// datapath: pointers, fill count, byte store and output register
`default_nettype none
module obrb_dp import obrb_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int MAX_READ = MAX_READ_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_item_t  in_data,
  input  wire cmd_t      cmd,
  output      status_t   status,
  output      out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > RLW) ? FW : RLW;
  localparam logic [AW-1:0]  LastIdx = AW'(DEPTH - 1);
  localparam logic [FW-1:0]  Full    = FW'(DEPTH);
  localparam logic [RLW-1:0] MaxRd   = RLW'(MAX_READ);

  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [RLW-1:0] rem_r, rem_nxt;
  logic [RLW-1:0] want, n_bytes;
  logic [CW-1:0]  want_c, fill_c;
  logic [FW+8:0]  fill_ext;
  logic [7:0]     ram_q;
  logic           rd_issue, is_full;
  out_item_t      out_r;

  // read length saturated, then limited by the fill count
  always_comb begin
    want    = ({1'b0, in_data.read_length} > MaxRd) ? MaxRd : {1'b0, in_data.read_length};
    want_c  = CW'(want);
    fill_c  = CW'(fill_r);
    n_bytes = (want_c < fill_c) ? want : RLW'(fill_c);
  end

  assign rd_issue = cmd.rd_start | cmd.rd_next;
  assign is_full  = (fill_r == Full);
  assign fill_ext = {9'd0, fill_r};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    rem_nxt    = rem_r;
    if (cmd.wr) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
      if (is_full) begin
        rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (rd_issue) begin
      rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
      rem_nxt    = cmd.rd_start ? n_bytes - 1'b1 : rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      rem_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      rem_r    <= rem_nxt;
    end
  end

  obrb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (wr_ptr_r),
    .wdata (in_data.write_byte),
    .re    (rd_issue),
    .raddr (rd_ptr_r),
    .rdata (ram_q)
  );

  // result register; on a capture the fill already reflects the byte just removed
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      out_r.read_byte  <= ram_q;
      out_r.last       <= (rem_r == '0);
      out_r.no_data    <= 1'b0;
      out_r.fill_level <= fill_ext[8:0];
    end else if (cmd.empty) begin
      out_r.read_byte  <= 8'd0;
      out_r.last       <= 1'b1;
      out_r.no_data    <= 1'b1;
      out_r.fill_level <= fill_ext[8:0];
    end
  end

  assign out_data        = out_r;
  assign status.n_zero   = (n_bytes == '0);
  assign status.out_last = out_r.last;

endmodule
`default_nettype wire

// File: rtl/core/overwriting_byte_ring_buffer.sv
// top level of the overwriting byte ring buffer
`default_nettype none
// Byte FIFO in a circular ram of DEPTH entries that drops its oldest byte
// when written while full. A write transaction (req_type 0) gives no
// result. A read transaction (req_type 1) returns
// min(read_length, MAX_READ, fill) bytes oldest first, the final one marked
// last; when that count is zero it returns a single result with no_data and
// last set. Every result carries the fill level left after it, low 9 bits.
// The input is taken only between reads: a read holds in_ready low until
// its final byte is taken at the output, and each byte passes in turn
// through the ram's registered read and then the output register; an empty
// read holds it low until its single result is taken. The ram holds
// no reset contents and needs no clearing pass: only bytes covered by the
// fill count are ever read.
module overwriting_byte_ring_buffer import obrb_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int MAX_READ = MAX_READ_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  // command and status between controller and datapath
  cmd_t    cmd;
  status_t status;

  // sequencing of write, fetch and result hand-off
  obrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .req_type  (in_data.req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // pointers, fill count, byte ram and result register
  obrb_dp #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/core/obrb_checker.sv
// port-level checks of the overwriting byte ring buffer and their bind
`default_nettype none
`include "overwriting_byte_ring_buffer_defines.svh"
module obrb_port_checks import obrb_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // a stalled result holds
  `OBRB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // an empty read is always a single, closing result
  `OBRB_ASSERT_NOW(a_empty_last, out_valid && out_data.no_data, out_data.last)

  // no new transaction is taken while a read is still streaming out
  `OBRB_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)

  // after a non-final byte the read continues and the input stays closed
  `OBRB_ASSERT_NEXT(a_read_continues, out_valid && out_ready && !out_data.last, !in_ready)

endmodule

bind overwriting_byte_ring_buffer obrb_port_checks u_chk (.*);
`default_nettype wire
